@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at an edge implies the consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent at an edge implies the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/dmfd_pkg.sv @@
// Types and constants for the double-marker frame detector.
package dmfd_pkg;

  localparam logic [7:0] FIRST_MARK = 8'hEB;
  localparam logic [7:0] TRAILER = 8'hD7;
  localparam logic [16:0] TRAILER_OFFSET = 17'd5;
  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  // Phase codes.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_DONE = 3'd1;
  localparam logic [2:0] ST_BAD_TRAILER = 3'd2;
  localparam logic [2:0] ST_NO_MARK2 = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  typedef struct packed {
    logic [1:0]  phase;
    logic [16:0] byte_position;
    logic [7:0]  length_high;
    logic [15:0] length_value;
  } dmfd_state_t;

endpackage

@@ hw/rtl/dmfd_step.sv @@
// Next-state and status logic of the frame detector for one received word.
module dmfd_step (
  input  dmfd_pkg::dmfd_state_t state,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           max_frame_len,
  output dmfd_pkg::dmfd_state_t state_next,
  output logic [2:0]            status,
  output logic                  in_frame
);
  import dmfd_pkg::*;

  logic [16:0] pos_inc;

  assign pos_inc = state.byte_position + 17'd1;

  always_comb begin
    state_next = state;
    status = ST_NONE;
    unique case (state.phase)
      PH_HEADER: begin
        state_next.byte_position = pos_inc;
        if (pos_inc == 17'd1) begin
          state_next.length_high = data_byte;
        end else if (pos_inc == 17'd2) begin
          state_next.length_value = {state.length_high, data_byte};
        end else if (data_byte != FIRST_MARK) begin
          status = ST_NO_MARK2;
          state_next.phase = PH_HUNT;
          state_next.byte_position = '0;
        end else if (state.length_value > max_frame_len) begin
          status = ST_TOO_LONG;
          state_next.phase = PH_HUNT;
          state_next.byte_position = '0;
        end else begin
          state_next.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        state_next.byte_position = pos_inc;
        // The trailer sits at position length + 5.
        if (pos_inc >= ({1'b0, state.length_value} + TRAILER_OFFSET)) begin
          status = (data_byte == TRAILER) ? ST_DONE : ST_BAD_TRAILER;
          state_next.phase = PH_HUNT;
          state_next.byte_position = '0;
        end
      end
      default: begin
        state_next.phase = PH_HUNT;
        if (data_byte == FIRST_MARK) begin
          state_next.phase = PH_HEADER;
          state_next.byte_position = '0;
          state_next.length_value = '0;
        end
      end
    endcase
    in_frame = (state_next.phase != PH_HUNT);
  end

endmodule

@@ hw/rtl/double_marker_frame_detector.sv @@
// Top level of the double-marker frame detector: input stage, state and result register.
// Takes one received byte per word and gives one result word per byte, in order. A byte is
// latched in the input stage, then the frame state and the result are updated together
// when it moves into the result register, so one word is accepted every clock cycle while
// the output side takes results. Frames are 0xEB, length high, length low, 0xEB, length+1
// payload bytes, trailer 0xD7; max_frame_len (reset 256) bounds the accepted length and
// should be written while idle.
module double_marker_frame_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        in_frame,
  output logic [15:0] frame_length
);
  import dmfd_pkg::*;

  logic [15:0] max_frame_len;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_move;
  dmfd_state_t state;
  dmfd_state_t state_next;
  logic [2:0]  status_next;
  logic        in_frame_next;

  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  dmfd_step u_step (
    .state         (state),
    .data_byte     (s1_byte),
    .max_frame_len (max_frame_len),
    .state_next    (state_next),
    .status        (status_next),
    .in_frame      (in_frame_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_frame_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_move) begin
        state <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      status <= status_next;
      in_frame <= in_frame_next;
      frame_length <= state_next.length_value;
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_no_phase3, clk, rst, state.phase != 2'd3, "unreachable phase entered")
  `ASSERT_IMPLIES(a_hunt_pos, clk, rst, state.phase == PH_HUNT, state.byte_position == 17'd0, "position not cleared while hunting")
  `ASSERT_IMPLIES(a_body_pos, clk, rst, state.phase == PH_BODY, state.byte_position < ({1'b0, state.length_value} + TRAILER_OFFSET), "body ran past the trailer")
  `ASSERT_IMPLIES(a_status_ends, clk, rst, out_valid && (status != ST_NONE), !in_frame, "frame still open after a final status")
  `ASSERT_NEXT(a_result_follows, clk, rst, s1_move, out_valid, "moved word produced no result")

endmodule

@@ tb/double_marker_frame_detector_tb.sv @@
// Self-checking testbench for the double-marker frame detector: framed and broken byte streams.
module double_marker_frame_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 12;
  localparam int PHASE_ITEMS = 165;

  typedef enum {FR_GOOD, FR_BAD_TRAILER, FR_NO_MARK2, FR_TOO_LONG} frame_kind_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        in_frame;
    logic [15:0] frame_length;
  } frame_result_t;

  // Tracks the frame state of the detector and queues the result due for every byte.
  class frame_scoreboard;
    logic [1:0]    phase;
    logic [16:0]   position;
    logic [7:0]    length_hi;
    logic [15:0]   length_val;
    logic [15:0]   max_len;
    frame_result_t expected_q[$];
    int            errors;
    int            checked;

    function new();
      phase = PH_HUNT;
      position = '0;
      length_hi = '0;
      length_val = '0;
      max_len = MAX_LEN_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void set_max_len(input logic [15:0] value);
      max_len = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(input logic [7:0] b);
      frame_result_t res;
      logic [2:0]    st;
      st = ST_NONE;
      case (phase)
        PH_HEADER: begin
          position = position + 17'd1;
          if (position == 17'd1) begin
            length_hi = b;
          end else if (position == 17'd2) begin
            length_val = {length_hi, b};
          end else if (b != FIRST_MARK) begin
            st = ST_NO_MARK2;
            phase = PH_HUNT;
            position = '0;
          end else if (length_val > max_len) begin
            st = ST_TOO_LONG;
            phase = PH_HUNT;
            position = '0;
          end else begin
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          position = position + 17'd1;
          // The trailer sits at length + 5 counted from the first marker.
          if ({15'd0, position} >= {16'd0, length_val} + {15'd0, TRAILER_OFFSET}) begin
            st = (b == TRAILER) ? ST_DONE : ST_BAD_TRAILER;
            phase = PH_HUNT;
            position = '0;
          end
        end
        default: begin
          phase = PH_HUNT;
          if (b == FIRST_MARK) begin
            phase = PH_HEADER;
            position = '0;
            length_val = '0;
          end
        end
      endcase
      res.status = st;
      res.in_frame = (phase != PH_HUNT);
      res.frame_length = length_val;
      expected_q.push_back(res);
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task check_result(input logic [2:0] st, input logic fr, input logic [15:0] len);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d in_frame=%0d length=%0d",
                                  st, fr, len));
      end else begin
        want = expected_q.pop_front();
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", st, want.status));
        if (fr !== want.in_frame)
          report_mismatch($sformatf("in_frame %0d, wanted %0d", fr, want.in_frame));
        if (len !== want.frame_length)
          report_mismatch($sformatf("frame_length %0d, wanted %0d", len, want.frame_length));
      end
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [2:0]  status;
  logic        in_frame;
  logic [15:0] frame_length;

  frame_scoreboard sb;
  int  cycle_count = 0;
  int  items_sent = 0;
  bit  send_gaps = 1'b1;
  bit  sink_stalls = 1'b1;

  double_marker_frame_detector DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .in_frame    (in_frame),
    .frame_length(frame_length)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(status, in_frame, frame_length);
  end

  // The result side stalls in random bursts while stalls are enabled.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Called just after the clock rises; returns once the input has taken the word.
  task automatic send_byte(input logic [7:0] b);
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_max_len(value);
  endtask

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == avoid) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [15:0] pick_length(input logic [15:0] max_len);
    int cap;
    cap = (max_len > 300) ? 300 : int'(max_len);
    if (max_len <= 300 && $urandom_range(0, 5) == 0) return max_len;
    if ($urandom_range(0, 19) == 0) return 16'($urandom_range(0, cap));
    return 16'($urandom_range(0, (cap > 12) ? 12 : cap));
  endfunction

  task automatic send_frame(input logic [15:0] len, input frame_kind_t kind);
    send_byte(FIRST_MARK);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (kind == FR_NO_MARK2) begin
      send_byte(byte_other_than(FIRST_MARK));
    end else begin
      send_byte(FIRST_MARK);
      if (kind != FR_TOO_LONG) begin
        for (int i = 0; i <= int'(len); i++) send_byte(8'($urandom_range(0, 255)));
        send_byte((kind == FR_BAD_TRAILER) ? byte_other_than(TRAILER) : TRAILER);
      end
    end
  endtask

  task automatic send_random_sequence();
    int          pick;
    logic [15:0] max_len;
    pick = $urandom_range(0, 99);
    max_len = sb.max_len;
    if (pick < 55) begin
      send_frame(pick_length(max_len), FR_GOOD);
    end else if (pick < 65) begin
      send_frame(pick_length(max_len), FR_BAD_TRAILER);
    end else if (pick < 73) begin
      send_frame(16'($urandom_range(0, 65535)), FR_NO_MARK2);
    end else if (pick < 83) begin
      if (max_len != 16'hFFFF)
        send_frame(16'($urandom_range(int'(max_len) + 1, 65535)), FR_TOO_LONG);
      else
        send_frame(pick_length(max_len), FR_GOOD);
    end else if (pick < 90) begin
      // A header cut short; whatever follows lands in the header fields.
      send_byte(FIRST_MARK);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_phase(input int budget, input bit pause_midway);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      send_random_sequence();
      if (pause_midway && items_sent - start >= budget / 2) begin
        drain_results();
        pause_midway = 1'b0;
      end
    end
  endtask

  task automatic send_opening();
    logic [7:0] opening[$];
    // Hunting noise, a good empty frame, a bad trailer, a missing second marker,
    // and two headers over the reset maximum.
    opening = '{8'h00, 8'hFF,
                FIRST_MARK, 8'h00, 8'h00, FIRST_MARK, 8'hFF, TRAILER,
                FIRST_MARK, 8'h00, 8'h01, FIRST_MARK, 8'h00, FIRST_MARK, 8'h00,
                FIRST_MARK, 8'h00, 8'h05, TRAILER,
                FIRST_MARK, 8'h01, 8'h01, FIRST_MARK,
                FIRST_MARK, 8'hFF, 8'hFF, FIRST_MARK};
    foreach (opening[i]) send_byte(opening[i]);
  endtask

  initial begin
    logic [15:0] settings[7];
    sb = new();
    settings = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 40)), MAX_LEN_RESET,
                 16'($urandom_range(0, 65535)), 16'd1, 16'($urandom_range(2, 300))};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_opening();
    for (int p = 0; p < 7; p++) begin
      write_max_len(settings[p]);
      send_gaps = (p != 3) && (p != 6);
      sink_stalls = (p != 3) && (p != 6);
      run_random_phase(PHASE_ITEMS, p == 2);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ double_marker_frame_detector.f @@
+incdir+hw/rtl
hw/rtl/dmfd_pkg.sv
hw/rtl/dmfd_step.sv
hw/rtl/double_marker_frame_detector.sv
tb/double_marker_frame_detector_tb.sv
